// ===== rtl/core/trp_pkg.sv =====
// ----------------------------------------------------------------------------
// trp_pkg
// Shared types and constants for the throttle packet receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trp_pkg;

    localparam logic [7:0] START_BYTE  = 8'hFA;
    localparam logic [7:0] ARM_BYTE    = 8'hFB;
    localparam logic [7:0] DISARM_BYTE = 8'hFC;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] REG_PERIOD_TOP    = 2'd0;
    localparam logic [1:0] REG_MIN_WIDTH     = 2'd1;
    localparam logic [1:0] REG_MAX_WIDTH     = 2'd2;
    localparam logic [1:0] REG_DISCONNECT_MS = 2'd3;

    localparam logic [15:0] PERIOD_TOP_RST    = 16'd39999;
    localparam logic [15:0] MIN_WIDTH_RST     = 16'd2000;
    localparam logic [15:0] MAX_WIDTH_RST     = 16'd4000;
    localparam logic [15:0] DISCONNECT_MS_RST = 16'd2000;
    localparam logic [15:0] COMPARE_RST       = 16'd37999;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^24
    localparam int          PROD_W      = 24;
    localparam int          QUOT_W      = 18;
    localparam logic [24:0] RECIP_100   = 25'd21474837;
    localparam int          RECIP_SHIFT = 31;

    typedef logic signed [19:0] wide_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_IDLE,
        ACT_SET
    } action_t;

    typedef struct packed {
        action_t action;
        logic    armed;
    } parse_t;

    function automatic logic [15:0] sat16(input wide_t v);
        logic [15:0] r;
        if (v < 0)
        begin
            r = 16'd0;
        end
        else if (v > wide_t'(20'sd65535))
        begin
            r = 16'hFFFF;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/trp_parser.sv =====
// ----------------------------------------------------------------------------
// trp_parser
// Packet framing, arm state and link watchdog; one request per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trp_parser
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          opcode,
    input  wire logic [7:0]    rx_byte,
    input  wire logic [15:0]   disconnect_ms,
    output trp_pkg::parse_t    result,
    output logic [7:0]         left_value,
    output logic [7:0]         right_value
);
    import trp_pkg::*;

    logic        start_reg, start_next;
    logic        lseen_reg, lseen_next;
    logic        rseen_reg, rseen_next;
    logic        arm_reg, arm_next;
    logic [7:0]  lval_reg, lval_next;
    logic [7:0]  rval_reg, rval_next;
    logic [15:0] silence_reg, silence_next;
    action_t     action;

    always_comb
    begin
        start_next   = start_reg;
        lseen_next   = lseen_reg;
        rseen_next   = rseen_reg;
        arm_next     = arm_reg;
        lval_next    = lval_reg;
        rval_next    = rval_reg;
        silence_next = silence_reg;
        action       = ACT_NONE;
        if (step)
        begin
            if (opcode == OP_BYTE)
            begin
                silence_next = 16'd0;
                if (rx_byte == START_BYTE)
                begin
                    start_next = 1'b1;
                end
                else if (start_reg)
                begin
                    if (!lseen_reg && !rseen_reg)
                    begin
                        lseen_next = 1'b1;
                        lval_next  = rx_byte;
                    end
                    else if (lseen_reg && !rseen_reg)
                    begin
                        rseen_next = 1'b1;
                        rval_next  = rx_byte;
                    end
                    else if (lseen_reg && rseen_reg)
                    begin
                        if (lval_reg == ARM_BYTE && rval_reg == ARM_BYTE)
                        begin
                            arm_next = 1'b1;
                        end
                        else if (lval_reg == DISARM_BYTE && rval_reg == DISARM_BYTE)
                        begin
                            arm_next = 1'b0;
                        end
                        else if ((lval_reg ^ rval_reg) == rx_byte && arm_reg)
                        begin
                            action = ACT_SET;
                        end
                        else if (!arm_reg)
                        begin
                            action = ACT_IDLE;
                        end
                        start_next = 1'b0;
                        lseen_next = 1'b0;
                        rseen_next = 1'b0;
                    end
                end
            end
            else
            begin
                if (silence_reg >= disconnect_ms)
                begin
                    action   = ACT_IDLE;
                    arm_next = 1'b0;
                end
                if (silence_reg != 16'hFFFF)
                begin
                    silence_next = silence_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg   <= 1'b0;
            lseen_reg   <= 1'b0;
            rseen_reg   <= 1'b0;
            arm_reg     <= 1'b0;
            lval_reg    <= 8'd0;
            rval_reg    <= 8'd0;
            silence_reg <= 16'd0;
        end
        else
        begin
            start_reg   <= start_next;
            lseen_reg   <= lseen_next;
            rseen_reg   <= rseen_next;
            arm_reg     <= arm_next;
            lval_reg    <= lval_next;
            rval_reg    <= rval_next;
            silence_reg <= silence_next;
        end
    end

    // values are unchanged on the checksum byte, so the stored ones feed scaling
    assign result.action = action;
    assign result.armed  = arm_next;
    assign left_value    = lval_reg;
    assign right_value   = rval_reg;

endmodule

`default_nettype wire

// ===== rtl/core/trp_scale.sv =====
// ----------------------------------------------------------------------------
// trp_scale
// Two-stage width offset: value * |span|, then divide by 100 via reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trp_scale
(
    input  wire logic                      clk,
    input  wire logic                      load_prod,
    input  wire logic                      load_quot,
    input  wire logic [7:0]                value,
    input  wire logic [15:0]               span_mag,
    output logic [trp_pkg::QUOT_W-1:0]     quot
);
    import trp_pkg::*;

    logic [PROD_W-1:0]    prod_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [PROD_W+24:0]   recip_prod;

    assign recip_prod = (PROD_W+25)'(prod_reg) * (PROD_W+25)'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (load_prod)
        begin
            prod_reg <= PROD_W'(value) * PROD_W'(span_mag);
        end
        if (load_quot)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
    end

    assign quot = quot_reg;

endmodule

`default_nettype wire

// ===== rtl/core/throttle_packet_receiver.sv =====
// ----------------------------------------------------------------------------
// throttle_packet_receiver
// Decodes throttle packets and ms ticks into two PWM compare values.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid, in_stall, opcode, rx_byte       request in
//  out      out_valid, out_stall, left_compare,       result out
//           right_compare, armed
//  cfg      cfg_write, cfg_index, cfg_data            register write
//
//  One request accepted per cycle while in_stall is low; it passes through
//  the input register, product stage, reciprocal stage and result register
//  to the outputs. The two multiplies per channel set the depth.
//  Stages advance independently, so empty stages keep filling while the
//  result register is stalled. Reset clears all control state and sets
//  both compare values to 37999.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module throttle_packet_receiver
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        opcode,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      left_compare,
    output logic [15:0]      right_compare,
    output logic             armed,
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    import trp_pkg::*;

    logic [15:0] period_top_reg, min_width_reg, max_width_reg, disconnect_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;
    logic load0, load1, load2, load3;

    logic        op0_reg;
    logic [7:0]  byte0_reg;
    action_t     act1_reg, act2_reg;
    logic        armed1_reg, armed2_reg, armed3_reg;
    logic [15:0] lcmp_reg, lcmp_next;
    logic [15:0] rcmp_reg, rcmp_next;

    parse_t      parse;
    logic [7:0]  left_value, right_value;
    logic        span_neg;
    logic [15:0] span_mag;
    logic [QUOT_W-1:0] lquot, rquot;
    wide_t       diff, lwide, rwide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_top_reg <= PERIOD_TOP_RST;
            min_width_reg  <= MIN_WIDTH_RST;
            max_width_reg  <= MAX_WIDTH_RST;
            disconnect_reg <= DISCONNECT_MS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PERIOD_TOP:    period_top_reg <= cfg_data;
                REG_MIN_WIDTH:     min_width_reg  <= cfg_data;
                REG_MAX_WIDTH:     max_width_reg  <= cfg_data;
                REG_DISCONNECT_MS: disconnect_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // handshake chain
    assign rdy3  = !v3_reg || !out_stall;
    assign rdy2  = !v2_reg || rdy3;
    assign rdy1  = !v1_reg || rdy2;
    assign rdy0  = !v0_reg || rdy1;
    assign load0 = in_valid && rdy0;
    assign load1 = v0_reg && rdy1;
    assign load2 = v1_reg && rdy2;
    assign load3 = v2_reg && rdy3;

    assign in_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= load0 || (v0_reg && !load1);
            v1_reg <= load1 || (v1_reg && !load2);
            v2_reg <= load2 || (v2_reg && !load3);
            v3_reg <= load3 || (v3_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            op0_reg   <= opcode;
            byte0_reg <= rx_byte;
        end
        if (load1)
        begin
            act1_reg   <= parse.action;
            armed1_reg <= parse.armed;
        end
        if (load2)
        begin
            act2_reg   <= act1_reg;
            armed2_reg <= armed1_reg;
        end
        if (load3)
        begin
            armed3_reg <= armed2_reg;
        end
    end

    trp_parser u_parser
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (load1),
        .opcode        (op0_reg),
        .rx_byte       (byte0_reg),
        .disconnect_ms (disconnect_reg),
        .result        (parse),
        .left_value    (left_value),
        .right_value   (right_value)
    );

    assign span_neg = max_width_reg < min_width_reg;
    assign span_mag = span_neg ? (min_width_reg - max_width_reg)
                               : (max_width_reg - min_width_reg);

    trp_scale u_scale_left
    (
        .clk       (clk),
        .load_prod (load1),
        .load_quot (load2),
        .value     (left_value),
        .span_mag  (span_mag),
        .quot      (lquot)
    );

    trp_scale u_scale_right
    (
        .clk       (clk),
        .load_prod (load1),
        .load_quot (load2),
        .value     (right_value),
        .span_mag  (span_mag),
        .quot      (rquot)
    );

    // compare = period_top - min_width -/+ offset
    assign diff  = wide_t'({4'd0, period_top_reg}) - wide_t'({4'd0, min_width_reg});
    assign lwide = span_neg ? (diff + wide_t'({2'd0, lquot})) : (diff - wide_t'({2'd0, lquot}));
    assign rwide = span_neg ? (diff + wide_t'({2'd0, rquot})) : (diff - wide_t'({2'd0, rquot}));

    always_comb
    begin
        lcmp_next = lcmp_reg;
        rcmp_next = rcmp_reg;
        case (act2_reg)
            ACT_IDLE:
            begin
                lcmp_next = sat16(diff);
                rcmp_next = sat16(diff);
            end
            ACT_SET:
            begin
                lcmp_next = sat16(lwide);
                rcmp_next = sat16(rwide);
            end
            default:
            begin
                lcmp_next = lcmp_reg;
                rcmp_next = rcmp_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcmp_reg <= COMPARE_RST;
            rcmp_reg <= COMPARE_RST;
        end
        else if (load3)
        begin
            lcmp_reg <= lcmp_next;
            rcmp_reg <= rcmp_next;
        end
    end

    assign out_valid     = v3_reg;
    assign left_compare  = lcmp_reg;
    assign right_compare = rcmp_reg;
    assign armed         = armed3_reg;

endmodule

`default_nettype wire

// ===== dv/throttle_packet_receiver_tb.sv =====
// ----------------------------------------------------------------------------
// throttle_packet_receiver_tb
// Self-checking bench: byte and tick requests go through a valid/stall
// channel, a scoreboard predicts the compare values and arm state per
// request and checks every result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module throttle_packet_receiver_tb;

    import trp_pkg::*;

    localparam int THROTTLE_FULL = 100;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        logic        armed;
    } pwm_state_t;

    class throttle_scoreboard;
        logic [15:0] period_top;
        logic [15:0] min_width;
        logic [15:0] max_width;
        logic [15:0] disconnect_ms;
        bit          start_seen;
        bit          left_seen;
        bit          right_seen;
        bit          arm_flag;
        logic [7:0]  left_value;
        logic [7:0]  right_value;
        logic [15:0] silence_ms;
        logic [15:0] left_cmp;
        logic [15:0] right_cmp;
        pwm_state_t  pwm_q[$];
        int          errors;

        function new();
            period_top    = PERIOD_TOP_RST;
            min_width     = MIN_WIDTH_RST;
            max_width     = MAX_WIDTH_RST;
            disconnect_ms = DISCONNECT_MS_RST;
            start_seen    = 0;
            left_seen     = 0;
            right_seen    = 0;
            arm_flag      = 0;
            left_value    = '0;
            right_value   = '0;
            silence_ms    = '0;
            left_cmp      = COMPARE_RST;
            right_cmp     = COMPARE_RST;
            errors        = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_PERIOD_TOP:    period_top = value;
                REG_MIN_WIDTH:     min_width = value;
                REG_MAX_WIDTH:     max_width = value;
                REG_DISCONNECT_MS: disconnect_ms = value;
                default: ;
            endcase
        endfunction

        function logic [15:0] clip(longint v);
            if (v < 0)
            begin
                return 16'd0;
            end
            if (v > 65535)
            begin
                return 16'hFFFF;
            end
            return v[15:0];
        endfunction

        function logic [15:0] throttle_compare(logic [7:0] value);
            longint span;
            longint q;
            span = longint'(max_width) - longint'(min_width);
            q = longint'(value) * span / THROTTLE_FULL;
            return clip(longint'(period_top) - (longint'(min_width) + q));
        endfunction

        function void go_idle();
            left_cmp  = clip(longint'(period_top) - longint'(min_width));
            right_cmp = left_cmp;
        endfunction

        function void take_byte(logic [7:0] b);
            silence_ms = '0;
            if (b == START_BYTE)
            begin
                start_seen = 1;
                return;
            end
            if (!start_seen)
            begin
                return;
            end
            if (!left_seen && !right_seen)
            begin
                left_seen  = 1;
                left_value = b;
            end
            else if (left_seen && !right_seen)
            begin
                right_seen  = 1;
                right_value = b;
            end
            else if (left_seen && right_seen)
            begin
                if (left_value == ARM_BYTE && right_value == ARM_BYTE)
                begin
                    arm_flag = 1;
                end
                else if (left_value == DISARM_BYTE && right_value == DISARM_BYTE)
                begin
                    arm_flag = 0;
                end
                else if ((left_value ^ right_value) == b && arm_flag)
                begin
                    left_cmp  = throttle_compare(left_value);
                    right_cmp = throttle_compare(right_value);
                end
                else if (!arm_flag)
                begin
                    go_idle();
                end
                start_seen = 0;
                left_seen  = 0;
                right_seen = 0;
            end
        endfunction

        function void note_request(logic op, logic [7:0] b);
            pwm_state_t s;
            if (op == OP_BYTE)
            begin
                take_byte(b);
            end
            else
            begin
                if (silence_ms >= disconnect_ms)
                begin
                    go_idle();
                    arm_flag = 0;
                end
                if (silence_ms != 16'hFFFF)
                begin
                    silence_ms = silence_ms + 16'd1;
                end
            end
            s.left  = left_cmp;
            s.right = right_cmp;
            s.armed = arm_flag;
            pwm_q.push_back(s);
        endfunction

        function void check_result(logic [15:0] l, logic [15:0] r, logic a);
            pwm_state_t s;
            if (pwm_q.size() == 0)
            begin
                $display("%0t result with no request pending: left %0d right %0d armed %0b",
                         $time, l, r, a);
                errors++;
                return;
            end
            s = pwm_q.pop_front();
            if (l !== s.left)
            begin
                $display("%0t left_compare expected %0d actual %0d", $time, s.left, l);
                errors++;
            end
            if (r !== s.right)
            begin
                $display("%0t right_compare expected %0d actual %0d", $time, s.right, r);
                errors++;
            end
            if (a !== s.armed)
            begin
                $display("%0t armed expected %0b actual %0b", $time, s.armed, a);
                errors++;
            end
        endfunction

        function int pending();
            return pwm_q.size();
        endfunction

        function void close_out();
            if (pwm_q.size() != 0)
            begin
                $display("%0t %0d results never arrived", $time, pwm_q.size());
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_BYTE;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] left_compare;
    logic [15:0] right_compare;
    logic        armed;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_PERIOD_TOP;
    logic [15:0] cfg_data = 16'd0;

    bit                 calm = 0;
    int                 sent = 0;
    throttle_scoreboard sb = new();

    throttle_packet_receiver dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .left_compare  (left_compare),
        .right_compare (right_compare),
        .armed         (armed),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 26);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(left_compare, right_compare, armed);
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(op, b);
        sent++;
    endtask

    task automatic stray_tick();
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(OP_TICK, 8'($urandom));
        end
    endtask

    task automatic send_packet(input logic [7:0] l, input logic [7:0] r,
                               input logic [7:0] chk);
        send_item(OP_BYTE, START_BYTE);
        stray_tick();
        send_item(OP_BYTE, l);
        stray_tick();
        send_item(OP_BYTE, r);
        stray_tick();
        send_item(OP_BYTE, chk);
    endtask

    function automatic logic [7:0] pick_throttle();
        if ($urandom_range(0, 3) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return 8'($urandom_range(0, 110));
    endfunction

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic load_config(input logic [15:0] pt, input logic [15:0] mw,
                               input logic [15:0] xw, input logic [15:0] dm);
        put_reg(REG_PERIOD_TOP, pt);
        put_reg(REG_MIN_WIDTH, mw);
        put_reg(REG_MAX_WIDTH, xw);
        put_reg(REG_DISCONNECT_MS, dm);
        cfg_write <= 1'b0;
    endtask

    task automatic settle();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic run_traffic(input int count, input bit quiet_middle);
        int          first;
        int          roll;
        int          reach;
        logic [7:0]  l;
        logic [7:0]  r;
        first = sent;
        while (sent - first < count)
        begin
            calm = quiet_middle && (sent - first > count / 3)
                   && (sent - first < 2 * count / 3);
            roll = $urandom_range(0, 99);
            l = pick_throttle();
            r = pick_throttle();
            if (roll < 55)
            begin
                send_packet(l, r, ($urandom_range(0, 3) != 0) ? (l ^ r) : 8'($urandom));
            end
            else if (roll < 63)
            begin
                send_packet(ARM_BYTE, ARM_BYTE, 8'($urandom));
            end
            else if (roll < 68)
            begin
                send_packet(DISARM_BYTE, DISARM_BYTE, 8'($urandom));
            end
            else if (roll < 80)
            begin
                reach = (sb.disconnect_ms > 37) ? 40 : int'(sb.disconnect_ms) + 3;
                repeat ($urandom_range(1, reach)) send_item(OP_TICK, 8'($urandom));
            end
            else if (roll < 90)
            begin
                send_item(OP_BYTE, ($urandom_range(0, 4) == 0) ? START_BYTE : 8'($urandom));
            end
            else
            begin
                send_item(OP_BYTE, START_BYTE);
                send_item(OP_BYTE, l);
                if ($urandom_range(0, 1) == 1)
                begin
                    send_item(OP_BYTE, r);
                end
            end
        end
        calm = 0;
    endtask

    initial
    begin
        logic [7:0] opening [];

        opening = '{
            8'h55,
            START_BYTE, 8'h10, 8'h20, 8'h30,
            START_BYTE, ARM_BYTE, ARM_BYTE, 8'h00,
            START_BYTE, 8'h00, 8'h64, 8'h64,
            START_BYTE, 8'hFF, 8'h00, 8'hFF,
            START_BYTE, 8'h01, 8'h02, 8'h07,
            START_BYTE, 8'h05, START_BYTE, 8'h07, 8'h02,
            START_BYTE, DISARM_BYTE, DISARM_BYTE, 8'h00
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte before start, disarmed packet, arm, throttle 0/100/255,
        // bad checksum, start byte in mid packet, disarm
        foreach (opening[i])
        begin
            send_item(OP_BYTE, opening[i]);
        end
        run_traffic(120, 0);

        settle();
        load_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'd5);
        run_traffic(120, 0);

        settle();
        load_config(16'h0000, 16'hFFFF, 16'h0000, 16'd0);
        run_traffic(110, 0);

        settle();
        load_config(16'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom_range(0, 30)));
        run_traffic(160, 1);

        settle();
        load_config(16'd20000, 16'd3000, 16'd1000, 16'd12);
        run_traffic(120, 0);

        // watchdog trips at the limit and on every later tick until a byte
        settle();
        load_config(PERIOD_TOP_RST, MIN_WIDTH_RST, MAX_WIDTH_RST, 16'd4);
        send_packet(ARM_BYTE, ARM_BYTE, 8'h00);
        send_packet(8'd40, 8'd70, 8'd40 ^ 8'd70);
        repeat (8) send_item(OP_TICK, 8'($urandom));
        send_item(OP_BYTE, 8'h33);
        repeat (3) send_item(OP_TICK, 8'($urandom));

        settle();
        sb.close_out();
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
